// File: rtl/core/ihp_pkg.sv
package ihp_pkg;

  localparam int FIXED_BYTES = 20;
  localparam int WORD_BYTES  = 4;
  localparam int POS_W       = $clog2(FIXED_BYTES);
  localparam int IDX_W       = 6;
  localparam int OUT_W       = 160;
  localparam int FIFO_DEPTH  = 2;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [3:0] VER_RESET = 4'd4;
  localparam logic [3:0] IHL_MIN   = 4'd5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TRUNC   = 2'd1,
    ST_BAD_VER = 2'd2,
    ST_BAD_IHL = 2'd3
  } status_t;

  // one command per header byte that touches the capture or closes a packet
  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic             clr;
    logic             cap;
    logic             emit;
    status_t          status;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic full;
    logic valid;
    cmd_t cmd;
  } fifo_stat_t;

  // header bytes in arrival order, byte k at hdr[k]
  typedef logic [FIXED_BYTES-1:0][7:0] hdr_t;

  function automatic logic [OUT_W-1:0] pack_hdr(input hdr_t h);
    pack_hdr = {4'b0000,
                h[16], h[17], h[18], h[19],
                h[12], h[13], h[14], h[15],
                h[10], h[11],
                h[9],
                h[8],
                h[6], h[7],
                h[4], h[5],
                h[2], h[3],
                h[1],
                h[0][3:0]};
  endfunction

endpackage

// File: rtl/core/ihp_front.sv
module ihp_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  input  logic [3:0]             exp_ver,
  output ihp_pkg::push_t         push
);

  typedef enum logic [3:0] {
    PH_START   = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_OPTIONS = 4'b0100,
    PH_DRAIN   = 4'b1000
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [ihp_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [3:0]                 ihl_r, ihl_nxt;
  logic [ihp_pkg::IDX_W-1:0]  opt_end;

  assign opt_end = ihp_pkg::IDX_W'(ihl_r) * ihp_pkg::IDX_W'(ihp_pkg::WORD_BYTES)
                   - ihp_pkg::IDX_W'(1);

  always_comb begin
    phase_nxt         = phase_r;
    idx_nxt           = idx_r;
    ihl_nxt           = ihl_r;
    push.valid        = 1'b0;
    push.cmd.data     = in_byte;
    push.cmd.pos      = idx_r[ihp_pkg::POS_W-1:0];
    push.cmd.clr      = 1'b0;
    push.cmd.cap      = 1'b0;
    push.cmd.emit     = 1'b0;
    push.cmd.status   = ihp_pkg::ST_OK;
    if (in_fire) begin
      unique case (phase_r)
        PH_START: begin
          push.valid    = 1'b1;
          push.cmd.pos  = '0;
          push.cmd.clr  = 1'b1;
          push.cmd.cap  = 1'b1;
          ihl_nxt       = in_byte[3:0];
          idx_nxt       = '0;
          if (in_byte[7:4] != exp_ver) begin
            push.cmd.emit   = 1'b1;
            push.cmd.status = ihp_pkg::ST_BAD_VER;
            phase_nxt       = in_last ? PH_START : PH_DRAIN;
          end else if (in_byte[3:0] < ihp_pkg::IHL_MIN) begin
            push.cmd.emit   = 1'b1;
            push.cmd.status = ihp_pkg::ST_BAD_IHL;
            phase_nxt       = in_last ? PH_START : PH_DRAIN;
          end else if (in_last) begin
            push.cmd.emit   = 1'b1;
            push.cmd.status = ihp_pkg::ST_TRUNC;
          end else begin
            idx_nxt   = ihp_pkg::IDX_W'(1);
            phase_nxt = PH_HEADER;
          end
        end
        PH_HEADER: begin
          push.valid   = 1'b1;
          push.cmd.cap = 1'b1;
          if (idx_r >= ihp_pkg::IDX_W'(ihp_pkg::FIXED_BYTES - 1)) begin
            if (ihl_r <= ihp_pkg::IHL_MIN) begin
              push.cmd.emit = 1'b1;
              idx_nxt       = '0;
              phase_nxt     = in_last ? PH_START : PH_DRAIN;
            end else if (in_last) begin
              push.cmd.emit   = 1'b1;
              push.cmd.status = ihp_pkg::ST_TRUNC;
              idx_nxt         = '0;
              phase_nxt       = PH_START;
            end else begin
              idx_nxt   = ihp_pkg::IDX_W'(ihp_pkg::FIXED_BYTES);
              phase_nxt = PH_OPTIONS;
            end
          end else if (in_last) begin
            push.cmd.emit   = 1'b1;
            push.cmd.status = ihp_pkg::ST_TRUNC;
            idx_nxt         = '0;
            phase_nxt       = PH_START;
          end else begin
            idx_nxt = idx_r + ihp_pkg::IDX_W'(1);
          end
        end
        PH_OPTIONS: begin
          // option bytes are skipped, only the closing byte goes back
          if (idx_r >= opt_end) begin
            push.valid    = 1'b1;
            push.cmd.emit = 1'b1;
            idx_nxt       = '0;
            phase_nxt     = in_last ? PH_START : PH_DRAIN;
          end else if (in_last) begin
            push.valid      = 1'b1;
            push.cmd.emit   = 1'b1;
            push.cmd.status = ihp_pkg::ST_TRUNC;
            idx_nxt         = '0;
            phase_nxt       = PH_START;
          end else begin
            idx_nxt = idx_r + ihp_pkg::IDX_W'(1);
          end
        end
        PH_DRAIN: begin
          if (in_last) begin
            idx_nxt   = '0;
            phase_nxt = PH_START;
          end
        end
        default: begin
          phase_nxt = PH_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      idx_r   <= '0;
      ihl_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      ihl_r   <= ihl_nxt;
    end
  end

endmodule

// File: rtl/core/ihp_fifo.sv
module ihp_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  ihp_pkg::push_t      push,
  input  logic                pop,
  output ihp_pkg::fifo_stat_t stat
);

  ihp_pkg::cmd_t              mem_r [ihp_pkg::FIFO_DEPTH];
  logic [ihp_pkg::PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [ihp_pkg::CNT_W-1:0]  cnt_r;
  logic                       do_push, do_pop;

  assign stat.full  = (cnt_r == ihp_pkg::CNT_W'(ihp_pkg::FIFO_DEPTH));
  assign stat.valid = (cnt_r != '0);
  assign stat.cmd   = mem_r[rd_ptr_r];

  assign do_push = push.valid && !stat.full;
  assign do_pop  = pop && stat.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + ihp_pkg::PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + ihp_pkg::PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + ihp_pkg::CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - ihp_pkg::CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/ihp_back.sv
module ihp_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ihp_pkg::fifo_stat_t       stat,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ihp_pkg::OUT_W-1:0] out_data,
  output logic [1:0]                out_user
);

  ihp_pkg::hdr_t              hdr_r, hdr_nxt;
  logic                       out_valid_r;
  logic [ihp_pkg::OUT_W-1:0]  out_data_r;
  logic [1:0]                 out_user_r;
  logic                       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  // a capture-only word never waits on the output side
  assign pop       = stat.valid && (!stat.cmd.emit || slot_free);

  always_comb begin
    hdr_nxt = hdr_r;
    if (pop) begin
      if (stat.cmd.clr) begin
        hdr_nxt = '0;
      end
      if (stat.cmd.cap) begin
        hdr_nxt[stat.cmd.pos] = stat.cmd.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
    if (pop && stat.cmd.emit) begin
      out_data_r <= ihp_pkg::pack_hdr(hdr_nxt);
      out_user_r <= stat.cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && stat.cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_user  = out_user_r;

endmodule

// File: rtl/core/ipv4_header_parser.sv
// channel  dir  handshake             payload
// in_      in   in_tvalid/in_tready   tdata: data_byte, tlast: last_byte
// out_     out  out_tvalid/out_tready tdata: header fields, tuser: status
// cfg_     in   cfg_valid/cfg_ready   cfg_data: version nibble to match
//
// one byte per cycle in while in_tready is high; the front classifies each byte as
// it is taken and queues kept and closing bytes; the back captures them from the FIFO
// closing word: FIFO, then the out_tvalid register, unless the back is held
// rst_n is synchronous, active low; no clearing pass after reset
// a waiting result holds the next closing word at the queue head; bytes keep
// coming in until the two-entry queue fills, then in_tready drops
module ipv4_header_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] data_byte
  input  logic                      in_tlast,   // last_byte
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [3:0] header_words, [11:4] service_type, [27:12] packet_length,
  // [43:28] ident, [59:44] flags_fragment, [67:60] time_to_live,
  // [75:68] proto_number, [91:76] header_checksum, [123:92] source_address,
  // [155:124] dest_address, [159:156] zero
  output logic [ihp_pkg::OUT_W-1:0] out_tdata,
  output logic [1:0]                out_tuser,  // [1:0] status
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [3:0]                cfg_data    // version nibble a header must carry
);

  logic [3:0]           exp_ver_r;
  logic                 in_fire;
  logic                 pop;
  ihp_pkg::push_t       push;
  ihp_pkg::fifo_stat_t  stat;

  assign cfg_ready = 1'b1;
  assign in_tready = !stat.full;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_ver_r <= ihp_pkg::VER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      exp_ver_r <= cfg_data;
    end
  end

  ihp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .exp_ver (exp_ver_r),
    .push    (push)
  );

  ihp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .stat  (stat)
  );

  ihp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_user  (out_tuser)
  );

endmodule

// File: rtl/core/ihp_checker.sv
module ihp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [ihp_pkg::OUT_W-1:0] out_tdata,
  input logic [1:0]                out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

  // an ok header always carried a legal length
  a_ok_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ihp_pkg::ST_OK |-> out_tdata[3:0] >= ihp_pkg::IHL_MIN)
    else $error("ok result with short header length");

  a_bad_ihl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ihp_pkg::ST_BAD_IHL |-> out_tdata[3:0] < ihp_pkg::IHL_MIN)
    else $error("short length status with legal length");

  // errors on the first byte leave every other field zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ihp_pkg::ST_BAD_VER || out_tuser == ihp_pkg::ST_BAD_IHL)
    |-> out_tdata[ihp_pkg::OUT_W-1:4] == '0)
    else $error("first-byte error carries header data");

endmodule

bind ipv4_header_parser ihp_checker u_ihp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: dv/ipv4_header_checker.sv
module ipv4_header_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] data_byte
  input  logic                      in_tlast,   // last_byte
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic [ihp_pkg::OUT_W-1:0] out_tdata,  // header fields, see port list of the block
  input  logic [1:0]                out_tuser,  // [1:0] status
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [3:0]                cfg_data,   // version nibble a header must carry
  output int                        mismatches,
  output int                        awaited
);

  typedef enum logic [1:0] {
    AT_FIRST,
    IN_FIXED,
    IN_OPTIONS,
    DROPPING
  } parse_phase_t;

  typedef struct packed {
    ihp_pkg::status_t status;
    logic [3:0]       header_words;
    logic [7:0]       service_type;
    logic [15:0]      packet_length;
    logic [15:0]      ident;
    logic [15:0]      flags_fragment;
    logic [7:0]       ttl;
    logic [7:0]       proto;
    logic [15:0]      checksum;
    logic [31:0]      src_addr;
    logic [31:0]      dst_addr;
  } ip_header_t;

  ip_header_t   pending_headers [$];
  logic [7:0]   hdr_bytes [ihp_pkg::FIXED_BYTES];
  parse_phase_t parse_phase;
  logic [5:0]   byte_pos;
  logic [3:0]   ihl_seen;
  logic [3:0]   version_reg;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_val);
    $display("mismatch in %s: got %0h, want %0h", what, got, want_val);
    mismatches++;
  endtask

  task automatic close_packet(input ihp_pkg::status_t st, input logic last_in);
    ip_header_t h;
    h.status         = st;
    h.header_words   = hdr_bytes[0][3:0];
    h.service_type   = hdr_bytes[1];
    h.packet_length  = {hdr_bytes[2], hdr_bytes[3]};
    h.ident          = {hdr_bytes[4], hdr_bytes[5]};
    h.flags_fragment = {hdr_bytes[6], hdr_bytes[7]};
    h.ttl            = hdr_bytes[8];
    h.proto          = hdr_bytes[9];
    h.checksum       = {hdr_bytes[10], hdr_bytes[11]};
    h.src_addr       = {hdr_bytes[12], hdr_bytes[13], hdr_bytes[14], hdr_bytes[15]};
    h.dst_addr       = {hdr_bytes[16], hdr_bytes[17], hdr_bytes[18], hdr_bytes[19]};
    pending_headers.push_back(h);
    parse_phase = last_in ? AT_FIRST : DROPPING;
    byte_pos    = '0;
  endtask

  task automatic parse_byte(input logic [7:0] d, input logic last_in);
    int k;
    int last_pos;
    case (parse_phase)
      AT_FIRST: begin
        // unreceived header bytes read back as zero
        for (k = 0; k < ihp_pkg::FIXED_BYTES; k++) hdr_bytes[k] = 8'h00;
        hdr_bytes[0] = d;
        ihl_seen     = d[3:0];
        if (d[7:4] != version_reg) begin
          close_packet(ihp_pkg::ST_BAD_VER, last_in);
        end else if (d[3:0] < ihp_pkg::IHL_MIN) begin
          close_packet(ihp_pkg::ST_BAD_IHL, last_in);
        end else if (last_in) begin
          close_packet(ihp_pkg::ST_TRUNC, 1'b1);
        end else begin
          byte_pos    = 6'd1;
          parse_phase = IN_FIXED;
        end
      end
      IN_FIXED: begin
        hdr_bytes[byte_pos] = d;
        if (byte_pos >= ihp_pkg::FIXED_BYTES - 1) begin
          if (ihl_seen <= ihp_pkg::IHL_MIN) begin
            close_packet(ihp_pkg::ST_OK, last_in);
          end else if (last_in) begin
            close_packet(ihp_pkg::ST_TRUNC, 1'b1);
          end else begin
            byte_pos    = 6'(ihp_pkg::FIXED_BYTES);
            parse_phase = IN_OPTIONS;
          end
        end else if (last_in) begin
          close_packet(ihp_pkg::ST_TRUNC, 1'b1);
        end else begin
          byte_pos = byte_pos + 6'd1;
        end
      end
      IN_OPTIONS: begin
        last_pos = int'(ihl_seen) * ihp_pkg::WORD_BYTES - 1;
        if (int'(byte_pos) >= last_pos) begin
          close_packet(ihp_pkg::ST_OK, last_in);
        end else if (last_in) begin
          close_packet(ihp_pkg::ST_TRUNC, 1'b1);
        end else begin
          byte_pos = byte_pos + 6'd1;
        end
      end
      default: begin
        if (last_in) begin
          parse_phase = AT_FIRST;
          byte_pos    = '0;
        end
      end
    endcase
  endtask

  task automatic check_result(input logic [ihp_pkg::OUT_W-1:0] d, input logic [1:0] st);
    ip_header_t want;
    if (pending_headers.size() == 0) begin
      report_mismatch("result with nothing pending", 32'(st), 32'd0);
    end else begin
      want = pending_headers.pop_front();
      if (st !== want.status) report_mismatch("status", 32'(st), 32'(want.status));
      if (d[3:0] !== want.header_words)
        report_mismatch("header_words", 32'(d[3:0]), 32'(want.header_words));
      if (d[11:4] !== want.service_type)
        report_mismatch("service_type", 32'(d[11:4]), 32'(want.service_type));
      if (d[27:12] !== want.packet_length)
        report_mismatch("packet_length", 32'(d[27:12]), 32'(want.packet_length));
      if (d[43:28] !== want.ident)
        report_mismatch("ident", 32'(d[43:28]), 32'(want.ident));
      if (d[59:44] !== want.flags_fragment)
        report_mismatch("flags_fragment", 32'(d[59:44]), 32'(want.flags_fragment));
      if (d[67:60] !== want.ttl)
        report_mismatch("time_to_live", 32'(d[67:60]), 32'(want.ttl));
      if (d[75:68] !== want.proto)
        report_mismatch("proto_number", 32'(d[75:68]), 32'(want.proto));
      if (d[91:76] !== want.checksum)
        report_mismatch("header_checksum", 32'(d[91:76]), 32'(want.checksum));
      if (d[123:92] !== want.src_addr)
        report_mismatch("source_address", d[123:92], want.src_addr);
      if (d[155:124] !== want.dst_addr)
        report_mismatch("dest_address", d[155:124], want.dst_addr);
      if (d[159:156] !== 4'b0000) report_mismatch("pad bits", 32'(d[159:156]), 32'd0);
    end
  endtask

  // results are checked before the byte of the same edge is parsed, so a
  // fresh expectation can never hide an early result
  always @(posedge clk) begin
    if (!rst_n) begin
      pending_headers.delete();
      parse_phase = AT_FIRST;
      byte_pos    = '0;
      ihl_seen    = '0;
      version_reg = ihp_pkg::VER_RESET;
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata, out_tuser);
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tlast);
      if (cfg_valid && cfg_ready) version_reg = cfg_data;
    end
    awaited = pending_headers.size();
  end

endmodule

// File: dv/tb_top.sv
module tb_top;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic [7:0]                in_tdata   = 8'h00;
  logic                      in_tlast   = 1'b0;
  logic                      out_tready = 1'b0;
  logic                      cfg_valid  = 1'b0;
  logic [3:0]                cfg_data   = 4'h0;
  wire                       in_tready;
  wire                       out_tvalid;
  wire [ihp_pkg::OUT_W-1:0]  out_tdata;
  wire [1:0]                 out_tuser;
  wire                       cfg_ready;

  int         mismatches;
  int         awaited;
  int         send_idle_pct = 0;
  int         stall_pct     = 0;
  bit         hold_request  = 1'b0;
  logic [3:0] cur_version   = ihp_pkg::VER_RESET;
  int         header_bytes_sent = 0;
  int         packets_sent      = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ipv4_header_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  ipv4_header_checker u_header_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  // result side: random stalls, or one long hold-off when asked for
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last_in);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last_in;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_run(input logic [7:0] bytes [$]);
    int k;
    for (k = 0; k < bytes.size(); k++) push_byte(bytes[k], k == bytes.size() - 1);
  endtask

  task automatic send_random_packet();
    logic [7:0] fixed_bytes [ihp_pkg::FIXED_BYTES];
    logic [3:0] ver;
    logic [3:0] ihl;
    int         kind;
    int         k;
    int         hdr_len;
    int         pkt_len;
    kind = $urandom_range(99);
    ver  = cur_version;
    ihl  = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 6)) : ihp_pkg::IHL_MIN;
    if (kind < 8) begin
      ver = cur_version ^ 4'($urandom_range(15, 1));
    end else if (kind < 14) begin
      ihl = 4'($urandom_range(4));
    end
    for (k = 0; k < ihp_pkg::FIXED_BYTES; k++) begin
      if (kind >= 95) fixed_bytes[k] = 8'hFF;
      else if (kind >= 90) fixed_bytes[k] = 8'h00;
      else fixed_bytes[k] = 8'($urandom);
    end
    fixed_bytes[0] = {ver, ihl};
    hdr_len = (ihl < ihp_pkg::IHL_MIN) ? ihp_pkg::FIXED_BYTES : int'(ihl) * ihp_pkg::WORD_BYTES;
    // some packets end right on the closing header byte
    pkt_len = hdr_len + (($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1));
    if (kind >= 14 && kind < 34) pkt_len = $urandom_range(hdr_len - 1, 1);
    for (k = 0; k < pkt_len; k++) begin
      push_byte((k < ihp_pkg::FIXED_BYTES) ? fixed_bytes[k] : 8'($urandom), k == pkt_len - 1);
    end
    if (kind < 14) header_bytes_sent += 1;
    else header_bytes_sent += (pkt_len < hdr_len) ? pkt_len : hdr_len;
    packets_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    // room for a result still in flight after a dropped tail
    repeat (10) @(negedge clk);
  endtask

  task automatic write_version(input logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid   <= 1'b0;
    cur_version = v;
  endtask

  initial begin
    logic [7:0] run [$];
    logic [3:0] version_plan [8];
    int         p;
    int         mode;
    int         byte_mark;
    int         pkt_mark;
    version_plan = '{4'd4, 4'd15, 4'd0, 4'd4, 4'd9, 4'd4, 4'd1, 4'd4};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: bad version, version beating short header, short header,
    // truncation at the first byte and mid header, full header of ones
    run = {8'h65};
    send_run(run);
    run = {8'h03};
    send_run(run);
    run = {8'h40};
    send_run(run);
    run = {8'h44, 8'h12, 8'h34};
    send_run(run);
    run = {8'h45};
    send_run(run);
    run = {8'h4F, 8'hFF, 8'h00};
    send_run(run);
    run = {8'h45};
    repeat (19) run.push_back(8'hFF);
    send_run(run);

    for (p = 0; p < 8; p++) begin
      wait_drained();
      write_version((p == 6) ? 4'($urandom) : version_plan[p]);
      mode          = p % 4;
      send_idle_pct = (mode == 1) ? 62 : (mode == 3) ? 18 : 0;
      stall_pct     = (mode == 2) ? 62 : (mode == 3) ? 18 : 0;
      if (p == 0) hold_request = 1'b1;
      byte_mark = header_bytes_sent;
      pkt_mark  = packets_sent;
      // the hold-off phase needs enough packets behind a parked result to fill the queue
      while (header_bytes_sent - byte_mark < 32 ||
             packets_sent - pkt_mark < ((p == 0) ? 4 : 2)) begin
        send_random_packet();
      end
    end

    in_tvalid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4_800_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
rtl/core/ihp_pkg.sv
rtl/core/ihp_front.sv
rtl/core/ihp_fifo.sv
rtl/core/ihp_back.sv
rtl/core/ipv4_header_parser.sv
rtl/core/ihp_checker.sv
dv/ipv4_header_checker.sv
dv/tb_top.sv
